/* rtl/tacs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, types and helper functions of the tile access cost stencil.
package tacs_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int LINE_LEN    = MAX_WIDTH - 1;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 7;
    localparam int HEIGHT_W    = 16;
    localparam int COST_W      = 32;
    localparam int WALK_W      = 31;
    localparam int ADDR_W      = 5;
    localparam int DATA_W      = 32;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_IDX_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = FIFO_IDX_W + 1;

    localparam logic [1:0] CLS_OTHER = 2'd0;
    localparam logic [1:0] CLS_ROAD  = 2'd1;
    localparam logic [1:0] CLS_ZONE  = 2'd2;

    typedef enum logic [2:0] {
        REG_GRID_WIDTH   = 3'd0,
        REG_GRID_HEIGHT  = 3'd1,
        REG_INCL_WATER   = 3'd2,
        REG_INCL_ROADS   = 3'd3,
        REG_INCL_ZONES   = 3'd4,
        REG_USE_ZONE_MAP = 3'd5,
        REG_INCL_ADJ     = 3'd6,
        REG_WALK_COST    = 3'd7
    } reg_idx_t;

    // One tile held in the window
    typedef struct packed {
        logic                     water;
        logic [1:0]               cls;
        logic signed [COST_W-1:0] cost;
        logic signed [COST_W-1:0] zone;
    } entry_t;

    typedef struct packed {
        entry_t above;
        entry_t left;
        entry_t center;
        entry_t right;
        entry_t below;
    } taps_t;

    // Bounds and frame flags of the tile whose result is due
    typedef struct packed {
        logic up_ok;
        logic left_ok;
        logic right_ok;
        logic down_ok;
        logic last;
    } emit_t;

    typedef struct packed {
        logic              include_water;
        logic              include_road_tiles;
        logic              include_zones;
        logic              use_zone_map;
        logic              include_adjacent;
        logic [WALK_W-1:0] walk_cost;
    } cfg_t;

    // Non-negative cost candidate
    typedef struct packed {
        logic              ok;
        logic [WALK_W-1:0] v;
    } cand_t;

    typedef struct packed {
        logic signed [COST_W-1:0] access_cost;
        logic                     last_tile;
    } result_t;

    function automatic cand_t cand_min(input cand_t a, input cand_t b);
        cand_t r;
        if (!a.ok)
            r = b;
        else if (!b.ok)
            r = a;
        else if (b.v < a.v)
            r = b;
        else
            r = a;
        return r;
    endfunction

    function automatic cand_t road_cand(input entry_t e, input logic present);
        cand_t r;
        r.ok = present && (e.cls == CLS_ROAD) && !e.cost[COST_W-1];
        r.v  = e.cost[WALK_W-1:0];
        return r;
    endfunction

    // Line cell at which a tile enters so that the line end sits one row back
    function automatic logic [COL_W-1:0] entry_pos(input logic [WIDTH_W-1:0] w);
        logic [WIDTH_W:0] d;
        d = (WIDTH_W+1)'(MAX_WIDTH) - {1'b0, w};
        return d[COL_W-1:0];
    endfunction

endpackage

/* rtl/tacs_tile_if.sv */
`timescale 1ns / 1ps
// Tile channel: valid/ready handshake carrying one grid tile or drain item.
interface tacs_tile_if;
    logic                             valid;
    logic                             ready;
    logic                             kind;
    logic                             is_water;
    logic [1:0]                       tile_class;
    logic signed [tacs_pkg::COST_W-1:0] road_cost;
    logic signed [tacs_pkg::COST_W-1:0] zone_road_cost;

    modport source (
        output valid, kind, is_water, tile_class, road_cost, zone_road_cost,
        input  ready
    );
    modport sink (
        input  valid, kind, is_water, tile_class, road_cost, zone_road_cost,
        output ready
    );
endinterface

/* rtl/tacs_cost_if.sv */
`timescale 1ns / 1ps
// Cost channel: valid/ready handshake carrying one access cost result.
interface tacs_cost_if;
    logic                             valid;
    logic                             ready;
    logic signed [tacs_pkg::COST_W-1:0] access_cost;
    logic                             last_tile;

    modport source (
        output valid, access_cost, last_tile,
        input  ready
    );
    modport sink (
        input  valid, access_cost, last_tile,
        output ready
    );
endinterface

/* rtl/tacs_cell.sv */
`timescale 1ns / 1ps
// One window cell: holds a tile, loads either the fresh tile or its neighbour.
module tacs_cell (
    input  logic             clk,
    input  logic             shift,
    input  logic             load_entry,
    input  tacs_pkg::entry_t entry_in,
    input  tacs_pkg::entry_t prev_in,
    output tacs_pkg::entry_t q
);

    tacs_pkg::entry_t q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= load_entry ? entry_in : prev_in;
        end
    end

    assign q = q_reg;

endmodule

/* rtl/tacs_window.sv */
`timescale 1ns / 1ps
// Two-row tile window built from a chain of cells with width-dependent entry points.
module tacs_window (
    input  logic                           clk,
    input  logic                           shift,
    input  tacs_pkg::entry_t               entry_in,
    input  logic [tacs_pkg::WIDTH_W-1:0]   width,
    output tacs_pkg::taps_t                taps
);

    localparam int LAST = tacs_pkg::LINE_LEN - 1;

    logic [tacs_pkg::COL_W-1:0] entry_idx;
    logic                       width_one;

    tacs_pkg::entry_t newest_q;
    tacs_pkg::entry_t center_q;
    tacs_pkg::entry_t left_q;
    tacs_pkg::entry_t line_a [tacs_pkg::LINE_LEN];
    tacs_pkg::entry_t line_b [tacs_pkg::LINE_LEN];

    assign entry_idx = tacs_pkg::entry_pos(width);
    assign width_one = (width == tacs_pkg::WIDTH_W'(1));

    tacs_cell u_newest (
        .clk        (clk),
        .shift      (shift),
        .load_entry (1'b1),
        .entry_in   (entry_in),
        .prev_in    (entry_in),
        .q          (newest_q)
    );

    // line_a: its end holds the right neighbour (age width-1)
    for (genvar j = 0; j < tacs_pkg::LINE_LEN; j++)
    begin : g_line_a
        if (j == 0)
        begin : g_head
            tacs_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .load_entry (1'b1),
                .entry_in   (newest_q),
                .prev_in    (newest_q),
                .q          (line_a[j])
            );
        end
        else
        begin : g_body
            tacs_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .load_entry (entry_idx == tacs_pkg::COL_W'(j)),
                .entry_in   (newest_q),
                .prev_in    (line_a[j-1]),
                .q          (line_a[j])
            );
        end
    end

    // a one-tile row skips line_a entirely
    tacs_cell u_center (
        .clk        (clk),
        .shift      (shift),
        .load_entry (width_one),
        .entry_in   (newest_q),
        .prev_in    (line_a[LAST]),
        .q          (center_q)
    );

    tacs_cell u_left (
        .clk        (clk),
        .shift      (shift),
        .load_entry (1'b1),
        .entry_in   (center_q),
        .prev_in    (center_q),
        .q          (left_q)
    );

    // line_b: its end holds the tile one row above the centre (age 2*width)
    for (genvar j = 0; j < tacs_pkg::LINE_LEN; j++)
    begin : g_line_b
        if (j == 0)
        begin : g_head
            tacs_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .load_entry (1'b1),
                .entry_in   (left_q),
                .prev_in    (left_q),
                .q          (line_b[j])
            );
        end
        else
        begin : g_body
            tacs_cell u_cell (
                .clk        (clk),
                .shift      (shift),
                .load_entry (entry_idx == tacs_pkg::COL_W'(j)),
                .entry_in   (left_q),
                .prev_in    (line_b[j-1]),
                .q          (line_b[j])
            );
        end
    end

    always_comb
    begin
        taps.above  = width_one ? left_q : line_b[LAST];
        taps.left   = left_q;
        taps.center = center_q;
        taps.right  = line_a[LAST];
        taps.below  = newest_q;
    end

endmodule

/* rtl/tacs_eval.sv */
`timescale 1ns / 1ps
// Cost evaluation pipeline: neighbour minimum, selection, walk cost add with saturation.
module tacs_eval (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              tap_valid,
    input  tacs_pkg::emit_t   info,
    input  tacs_pkg::taps_t   taps,
    input  tacs_pkg::cfg_t    cfg,
    output logic              res_valid,
    output tacs_pkg::result_t res,
    output logic [1:0]        in_flight
);

    typedef struct packed {
        logic                        last;
        logic                        excl;
        logic                        direct;
        logic                        own_ok;
        logic [tacs_pkg::WALK_W-1:0] own;
        logic                        zone_tile;
        logic                        map_ok;
        logic [tacs_pkg::WALK_W-1:0] zc;
        tacs_pkg::cand_t             pair_a;
        tacs_pkg::cand_t             pair_b;
    } s2_t;

    typedef struct packed {
        logic                        last;
        logic                        neg;
        logic                        add;
        logic [tacs_pkg::WALK_W-1:0] val;
    } s3_t;

    s2_t  s2_next, s2_reg;
    s3_t  s3_next, s3_reg;
    logic s2_valid_reg, s3_valid_reg;

    tacs_pkg::entry_t            c;
    tacs_pkg::cand_t             adj, m;
    logic [tacs_pkg::COST_W-1:0] sum;

    // stage 2: per-tap checks and pairwise minimum
    always_comb
    begin
        c                 = taps.center;
        s2_next.last      = info.last;
        s2_next.excl      = c.water && !cfg.include_water;
        s2_next.direct    = cfg.include_road_tiles && (c.cls == tacs_pkg::CLS_ROAD);
        s2_next.own_ok    = !c.cost[tacs_pkg::COST_W-1];
        s2_next.own       = c.cost[tacs_pkg::WALK_W-1:0];
        s2_next.zone_tile = cfg.include_zones && (c.cls == tacs_pkg::CLS_ZONE);
        s2_next.map_ok    = cfg.use_zone_map && !c.zone[tacs_pkg::COST_W-1];
        s2_next.zc        = c.zone[tacs_pkg::WALK_W-1:0];
        s2_next.pair_a    = tacs_pkg::cand_min(tacs_pkg::road_cand(taps.above, info.up_ok),
                                               tacs_pkg::road_cand(taps.left, info.left_ok));
        s2_next.pair_b    = tacs_pkg::cand_min(tacs_pkg::road_cand(taps.right, info.right_ok),
                                               tacs_pkg::road_cand(taps.below, info.down_ok));
    end

    // stage 3: final minimum and choice of source
    always_comb
    begin
        adj = tacs_pkg::cand_min(s2_reg.pair_a, s2_reg.pair_b);
        if (s2_reg.zone_tile && s2_reg.map_ok)
        begin
            m.ok = 1'b1;
            m.v  = s2_reg.zc;
        end
        else if (cfg.include_adjacent)
        begin
            m = adj;
        end
        else
        begin
            m = '0;
        end

        s3_next.last = s2_reg.last;
        if (s2_reg.excl)
        begin
            s3_next.neg = 1'b1;
            s3_next.add = 1'b0;
            s3_next.val = s2_reg.own;
        end
        else if (s2_reg.direct)
        begin
            s3_next.neg = !s2_reg.own_ok;
            s3_next.add = 1'b0;
            s3_next.val = s2_reg.own;
        end
        else
        begin
            s3_next.neg = !m.ok;
            s3_next.add = 1'b1;
            s3_next.val = m.v;
        end
    end

    // final: walk cost add, saturating
    always_comb
    begin
        sum           = {1'b0, s3_reg.val} + {1'b0, cfg.walk_cost};
        res.last_tile = s3_reg.last;
        if (s3_reg.neg)
            res.access_cost = -32'sd1;
        else if (s3_reg.add && sum[tacs_pkg::COST_W-1])
            res.access_cost = 32'sh7FFF_FFFF;
        else if (s3_reg.add)
            res.access_cost = $signed(sum);
        else
            res.access_cost = $signed({1'b0, s3_reg.val});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= tap_valid;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_reg <= s2_next;
        s3_reg <= s3_next;
    end

    assign res_valid = s3_valid_reg;
    assign in_flight = {1'b0, s2_valid_reg} + {1'b0, s3_valid_reg};

endmodule

/* rtl/tacs_fifo.sv */
`timescale 1ns / 1ps
// Result queue between the evaluation pipeline and the cost channel.
module tacs_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  tacs_pkg::result_t                 push_data,
    output logic                              pop_valid,
    input  logic                              pop_ready,
    output tacs_pkg::result_t                 pop_data,
    output logic [tacs_pkg::FIFO_CNT_W-1:0]   count
);

    tacs_pkg::result_t mem_reg [tacs_pkg::FIFO_DEPTH];

    logic [tacs_pkg::FIFO_IDX_W-1:0] head_reg, head_next;
    logic [tacs_pkg::FIFO_IDX_W-1:0] tail_reg, tail_next;
    logic [tacs_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                            pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = mem_reg[head_reg];
    assign count     = count_reg;

    always_comb
    begin
        head_next  = pop  ? head_reg + 1'b1 : head_reg;
        tail_next  = push ? tail_reg + 1'b1 : tail_reg;
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[tail_reg] <= push_data;
        end
    end

endmodule

/* rtl/tile_access_cost_stencil.sv */
`timescale 1ns / 1ps
// Top level of the tile access cost stencil: register port, frame counters, window and pipeline.
//
// Tiles enter on tile_ch in raster order, one item per cycle while tile_ch.ready is high;
// each gets an access cost on cost_ch (-1 when excluded or unreachable), last_tile marking
// the frame's final tile. The result for a tile needs the tile one row below, so it is
// produced when that tile arrives; row 0 produces nothing and the last row is flushed by
// grid_width drain items (kind = 1). A tile item after the frame end starts a new frame.
// A released result passes the s1, s2 and s3 pipeline registers and the result queue
// before cost_ch.valid rises. Throughput: one item per cycle while tile_ch.ready is high,
// set by the window cell chain which shifts once per tile. A queue of 8 results decouples
// the receiver; when the results queued and in the pipeline reach 8, tile_ch.ready falls
// until the receiver takes one.
// Reset clears all registers to their reset values and restarts the frame; window
// contents are not cleared. Writing grid_width or grid_height restarts the frame and
// drops results not yet released; released ones still go out. Registers sit at byte
// address 4*index, writes complete with no wait states and reads return the stored value.
module tile_access_cost_stencil (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tacs_pkg::ADDR_W-1:0]   paddr,
    input  logic [tacs_pkg::DATA_W-1:0]   pwdata,
    output logic [tacs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    tacs_tile_if.sink                     tile_ch,
    tacs_cost_if.source                   cost_ch
);

    localparam int LOAD_W = tacs_pkg::FIFO_CNT_W + 1;

    logic [tacs_pkg::WIDTH_W-1:0]  grid_width_reg;
    logic [tacs_pkg::HEIGHT_W-1:0] grid_height_reg;
    logic                          include_water_reg;
    logic                          include_road_tiles_reg;
    logic                          include_zones_reg;
    logic                          use_zone_map_reg;
    logic                          include_adjacent_reg;
    logic [tacs_pkg::WALK_W-1:0]   walk_cost_reg;

    logic [tacs_pkg::COL_W-1:0]    in_col_reg, in_col_next, in_col_base;
    logic [tacs_pkg::HEIGHT_W-1:0] in_row_reg, in_row_next, in_row_base;
    logic [tacs_pkg::COL_W-1:0]    out_col_reg, out_col_next;
    logic [tacs_pkg::HEIGHT_W-1:0] out_row_reg, out_row_next;

    logic                          s1_valid_reg;
    tacs_pkg::emit_t               s1_info_reg, emit_info;

    logic [tacs_pkg::WIDTH_W-1:0]  w_eff;
    logic [tacs_pkg::HEIGHT_W-1:0] h_eff;
    logic                          cfg_wr;
    tacs_pkg::reg_idx_t            reg_sel;
    logic                          geom_wr;
    logic                          accept, frame_done, push, emit;
    logic [tacs_pkg::WIDTH_W-1:0]  in_col_plus, out_col_plus;
    logic [tacs_pkg::HEIGHT_W:0]   out_row_plus, h_ext;
    tacs_pkg::entry_t              new_entry;
    tacs_pkg::taps_t               taps;
    tacs_pkg::cfg_t                cfg;
    logic                          res_valid;
    tacs_pkg::result_t             res;
    logic [1:0]                    eval_in_flight;
    logic [tacs_pkg::FIFO_CNT_W-1:0] fifo_count;
    logic [LOAD_W-1:0]             load;
    tacs_pkg::result_t             pop_data;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = tacs_pkg::reg_idx_t'(paddr[tacs_pkg::ADDR_W-1:2]);
    assign geom_wr = cfg_wr && (reg_sel == tacs_pkg::REG_GRID_WIDTH ||
                                reg_sel == tacs_pkg::REG_GRID_HEIGHT);

    always_comb
    begin
        case (reg_sel)
            tacs_pkg::REG_GRID_WIDTH:   prdata = tacs_pkg::DATA_W'(grid_width_reg);
            tacs_pkg::REG_GRID_HEIGHT:  prdata = tacs_pkg::DATA_W'(grid_height_reg);
            tacs_pkg::REG_INCL_WATER:   prdata = tacs_pkg::DATA_W'(include_water_reg);
            tacs_pkg::REG_INCL_ROADS:   prdata = tacs_pkg::DATA_W'(include_road_tiles_reg);
            tacs_pkg::REG_INCL_ZONES:   prdata = tacs_pkg::DATA_W'(include_zones_reg);
            tacs_pkg::REG_USE_ZONE_MAP: prdata = tacs_pkg::DATA_W'(use_zone_map_reg);
            tacs_pkg::REG_INCL_ADJ:     prdata = tacs_pkg::DATA_W'(include_adjacent_reg);
            tacs_pkg::REG_WALK_COST:    prdata = tacs_pkg::DATA_W'(walk_cost_reg);
            default:                    prdata = '0;
        endcase
    end

    // zero width or height act as one, width clamps to the window size
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = tacs_pkg::WIDTH_W'(1);
        else if (grid_width_reg > tacs_pkg::WIDTH_W'(tacs_pkg::MAX_WIDTH))
            w_eff = tacs_pkg::WIDTH_W'(tacs_pkg::MAX_WIDTH);
        else
            w_eff = grid_width_reg;
        h_eff = (grid_height_reg == '0) ? tacs_pkg::HEIGHT_W'(1) : grid_height_reg;
    end

    assign cfg.include_water      = include_water_reg;
    assign cfg.include_road_tiles = include_road_tiles_reg;
    assign cfg.include_zones      = include_zones_reg;
    assign cfg.use_zone_map       = use_zone_map_reg;
    assign cfg.include_adjacent   = include_adjacent_reg;
    assign cfg.walk_cost          = walk_cost_reg;

    // credit: results in the pipeline plus those queued never exceed the queue depth
    assign load = LOAD_W'(fifo_count) + LOAD_W'(s1_valid_reg) + LOAD_W'(eval_in_flight);
    assign tile_ch.ready = (load < LOAD_W'(tacs_pkg::FIFO_DEPTH));
    assign accept        = tile_ch.valid && tile_ch.ready;
    assign frame_done    = (in_row_reg >= h_eff);

    always_comb
    begin
        out_col_plus       = tacs_pkg::WIDTH_W'(out_col_reg) + 1'b1;
        out_row_plus       = {1'b0, out_row_reg} + 1'b1;
        h_ext              = {1'b0, h_eff};
        emit_info.up_ok    = (out_row_reg != '0);
        emit_info.left_ok  = (out_col_reg != '0);
        emit_info.right_ok = (out_col_plus < w_eff);
        emit_info.down_ok  = (out_row_plus < h_ext);
        emit_info.last     = (out_row_plus == h_ext) && (out_col_plus == w_eff);
    end

    always_comb
    begin
        if (tile_ch.kind)
        begin
            new_entry.water = 1'b0;
            new_entry.cls   = tacs_pkg::CLS_OTHER;
            new_entry.cost  = -32'sd1;
            new_entry.zone  = -32'sd1;
        end
        else
        begin
            new_entry.water = tile_ch.is_water;
            new_entry.cls   = tile_ch.tile_class;
            new_entry.cost  = tile_ch.road_cost;
            new_entry.zone  = tile_ch.zone_road_cost;
        end
    end

    always_comb
    begin
        push         = 1'b0;
        emit         = 1'b0;
        in_col_base  = in_col_reg;
        in_row_base  = in_row_reg;
        in_col_plus  = tacs_pkg::WIDTH_W'(in_col_reg) + 1'b1;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;

        if (geom_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (accept)
        begin
            if (tile_ch.kind)
            begin
                // drain: only after the frame while results are still pending
                if (frame_done && (out_row_reg < h_eff))
                begin
                    push = 1'b1;
                    emit = 1'b1;
                end
            end
            else
            begin
                push = 1'b1;
                if (frame_done)
                begin
                    in_col_base  = '0;
                    in_row_base  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else
                begin
                    emit = (in_row_reg != '0);
                end
                in_col_plus = tacs_pkg::WIDTH_W'(in_col_base) + 1'b1;
                if (in_col_plus >= w_eff)
                begin
                    in_col_next = '0;
                    in_row_next = in_row_base + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_plus[tacs_pkg::COL_W-1:0];
                    in_row_next = in_row_base;
                end
            end

            if (emit)
            begin
                if (out_col_plus >= w_eff)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_plus[tacs_pkg::COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg         <= tacs_pkg::WIDTH_W'(tacs_pkg::MAX_WIDTH);
            grid_height_reg        <= tacs_pkg::HEIGHT_W'(64);
            include_water_reg      <= 1'b0;
            include_road_tiles_reg <= 1'b1;
            include_zones_reg      <= 1'b1;
            use_zone_map_reg       <= 1'b1;
            include_adjacent_reg   <= 1'b1;
            walk_cost_reg          <= '0;
            in_col_reg             <= '0;
            in_row_reg             <= '0;
            out_col_reg            <= '0;
            out_row_reg            <= '0;
            s1_valid_reg           <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                case (reg_sel)
                    tacs_pkg::REG_GRID_WIDTH:
                        grid_width_reg <= pwdata[tacs_pkg::WIDTH_W-1:0];
                    tacs_pkg::REG_GRID_HEIGHT:
                        grid_height_reg <= pwdata[tacs_pkg::HEIGHT_W-1:0];
                    tacs_pkg::REG_INCL_WATER:   include_water_reg      <= pwdata[0];
                    tacs_pkg::REG_INCL_ROADS:   include_road_tiles_reg <= pwdata[0];
                    tacs_pkg::REG_INCL_ZONES:   include_zones_reg      <= pwdata[0];
                    tacs_pkg::REG_USE_ZONE_MAP: use_zone_map_reg       <= pwdata[0];
                    tacs_pkg::REG_INCL_ADJ:     include_adjacent_reg   <= pwdata[0];
                    tacs_pkg::REG_WALK_COST:
                        walk_cost_reg <= pwdata[tacs_pkg::WALK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            in_col_reg   <= in_col_next;
            in_row_reg   <= in_row_next;
            out_col_reg  <= out_col_next;
            out_row_reg  <= out_row_next;
            s1_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s1_info_reg <= emit_info;
        end
    end

    tacs_window u_window (
        .clk      (clk),
        .shift    (push),
        .entry_in (new_entry),
        .width    (w_eff),
        .taps     (taps)
    );

    tacs_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .tap_valid (s1_valid_reg),
        .info      (s1_info_reg),
        .taps      (taps),
        .cfg       (cfg),
        .res_valid (res_valid),
        .res       (res),
        .in_flight (eval_in_flight)
    );

    tacs_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop_valid (cost_ch.valid),
        .pop_ready (cost_ch.ready),
        .pop_data  (pop_data),
        .count     (fifo_count)
    );

    assign cost_ch.access_cost = pop_data.access_cost;
    assign cost_ch.last_tile   = pop_data.last_tile;

endmodule

/* sim/tile_access_cost_stencil_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the tile access cost stencil: directed table, then random frames.
module tile_access_cost_stencil_tb;

    localparam int WINDOW_LEN      = 2 * tacs_pkg::MAX_WIDTH + 1;
    localparam int ZONE_WINDOW_LEN = tacs_pkg::MAX_WIDTH + 1;
    localparam int COST_SAT        = 2147483647;
    localparam int SETTLE_CYCLES   = 12;
    localparam int RANDOM_ITEMS    = 550;
    localparam logic KIND_TILE     = 1'b0;
    localparam logic KIND_DRAIN    = 1'b1;
    localparam logic [1:0] CLS_SPARE = 2'd3;

    typedef struct packed {
        logic                               kind;
        logic                               is_water;
        logic [1:0]                         tile_class;
        logic signed [tacs_pkg::COST_W-1:0] road_cost;
        logic signed [tacs_pkg::COST_W-1:0] zone_road_cost;
    } tile_t;

    typedef enum bit {ACT_WRITE, ACT_ITEM} act_e;

    typedef struct {
        act_e                        act;
        tacs_pkg::reg_idx_t          idx;
        logic [tacs_pkg::DATA_W-1:0] value;
        tile_t                       item;
        bit                          typed;
        tacs_pkg::result_t           want;
    } script_row_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [tacs_pkg::ADDR_W-1:0] paddr;
    logic [tacs_pkg::DATA_W-1:0] pwdata;
    logic [tacs_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    tacs_tile_if tile_ch ();
    tacs_cost_if cost_ch ();

    tile_access_cost_stencil dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tile_ch (tile_ch),
        .cost_ch (cost_ch)
    );

    // Predictor state
    logic [tacs_pkg::WIDTH_W-1:0]       grid_w_reg;
    logic [tacs_pkg::HEIGHT_W-1:0]      grid_h_reg;
    tacs_pkg::cfg_t                     knobs;
    logic [2:0]                         class_win [WINDOW_LEN];
    logic signed [tacs_pkg::COST_W-1:0] cost_win [WINDOW_LEN];
    logic signed [tacs_pkg::COST_W-1:0] zone_win [ZONE_WINDOW_LEN];
    int                                 in_col, in_row, out_col, out_row;

    tacs_pkg::result_t pending_costs [$];
    tacs_pkg::result_t due;
    script_row_t       script [$];
    int                mismatches, costs_checked, tile_items, drain_items, counted_items;
    int                settings_used;
    bit                src_steady, sink_steady;
    int                sink_hold;

    function automatic int span_w();
        if (grid_w_reg == 0)
            return 1;
        return (grid_w_reg > tacs_pkg::MAX_WIDTH) ? tacs_pkg::MAX_WIDTH : int'(grid_w_reg);
    endfunction

    function automatic int span_h();
        return (grid_h_reg == 0) ? 1 : int'(grid_h_reg);
    endfunction

    function automatic void restart_frame();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void predictor_reset();
        grid_w_reg               = 7'd64;
        grid_h_reg               = 16'd64;
        knobs.include_water      = 1'b0;
        knobs.include_road_tiles = 1'b1;
        knobs.include_zones      = 1'b1;
        knobs.use_zone_map       = 1'b1;
        knobs.include_adjacent   = 1'b1;
        knobs.walk_cost          = '0;
        for (int i = 0; i < WINDOW_LEN; i++)
        begin
            class_win[i] = '0;
            cost_win[i]  = '0;
        end
        for (int i = 0; i < ZONE_WINDOW_LEN; i++)
            zone_win[i] = '0;
        restart_frame();
    endfunction

    function automatic void apply_register(input tacs_pkg::reg_idx_t r,
                                           input logic [tacs_pkg::DATA_W-1:0] v);
        case (r)
            tacs_pkg::REG_GRID_WIDTH:
            begin
                grid_w_reg = v[tacs_pkg::WIDTH_W-1:0];
                restart_frame();
            end
            tacs_pkg::REG_GRID_HEIGHT:
            begin
                grid_h_reg = v[tacs_pkg::HEIGHT_W-1:0];
                restart_frame();
            end
            tacs_pkg::REG_INCL_WATER:   knobs.include_water      = v[0];
            tacs_pkg::REG_INCL_ROADS:   knobs.include_road_tiles = v[0];
            tacs_pkg::REG_INCL_ZONES:   knobs.include_zones      = v[0];
            tacs_pkg::REG_USE_ZONE_MAP: knobs.use_zone_map       = v[0];
            tacs_pkg::REG_INCL_ADJ:     knobs.include_adjacent   = v[0];
            tacs_pkg::REG_WALK_COST:    knobs.walk_cost = v[tacs_pkg::WALK_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void shift_window(input logic [2:0] c,
                                         input logic signed [tacs_pkg::COST_W-1:0] rc,
                                         input logic signed [tacs_pkg::COST_W-1:0] zc);
        for (int i = WINDOW_LEN - 1; i > 0; i--)
        begin
            class_win[i] = class_win[i-1];
            cost_win[i]  = cost_win[i-1];
        end
        for (int i = ZONE_WINDOW_LEN - 1; i > 0; i--)
            zone_win[i] = zone_win[i-1];
        class_win[0] = c;
        cost_win[0]  = rc;
        zone_win[0]  = zc;
    endfunction

    // Cheapest reachable road among the neighbours
    function automatic void take_road(input int age, input bit present, inout longint best);
        if (!present)
            return;
        if (class_win[age][1:0] != tacs_pkg::CLS_ROAD || cost_win[age] < 0)
            return;
        if (best < 0 || cost_win[age] < best)
            best = cost_win[age];
    endfunction

    // Tile due for a result sits one row back from the newest tile
    function automatic logic signed [tacs_pkg::COST_W-1:0] centre_cost();
        int         w, h;
        logic [1:0] cls;
        logic       water;
        longint     own, zc, adj, m;
        w     = span_w();
        h     = span_h();
        cls   = class_win[w][1:0];
        water = class_win[w][2];
        own   = cost_win[w];
        zc    = zone_win[w];
        adj   = -1;
        m     = -1;
        if (water && !knobs.include_water)
            return -1;
        if (knobs.include_road_tiles && cls == tacs_pkg::CLS_ROAD)
            return (own < 0) ? -1 : tacs_pkg::COST_W'(own);
        take_road(2 * w, out_row > 0, adj);
        take_road(w + 1, out_col > 0, adj);
        take_road(w - 1, out_col + 1 < w, adj);
        take_road(0, out_row + 1 < h, adj);
        if (knobs.include_zones && cls == tacs_pkg::CLS_ZONE)
        begin
            if (knobs.use_zone_map && zc >= 0)
                m = zc;
            if (m < 0 && knobs.include_adjacent)
                m = adj;
        end
        else if (knobs.include_adjacent)
        begin
            m = adj;
        end
        if (m < 0)
            return -1;
        m = m + longint'(knobs.walk_cost);
        if (m > COST_SAT)
            m = COST_SAT;
        return tacs_pkg::COST_W'(m);
    endfunction

    function automatic tacs_pkg::result_t release_result();
        tacs_pkg::result_t r;
        int                w, h;
        w             = span_w();
        h             = span_h();
        r.access_cost = centre_cost();
        r.last_tile   = (out_row + 1 == h) && (out_col + 1 == w);
        out_col++;
        if (out_col >= w)
        begin
            out_col = 0;
            out_row++;
        end
        return r;
    endfunction

    function automatic bit stencil_step(input tile_t t, output tacs_pkg::result_t r);
        int w, h;
        bit made;
        w    = span_w();
        h    = span_h();
        r    = '0;
        made = 1'b0;
        if (t.kind == KIND_DRAIN)
        begin
            if (in_row >= h && out_row < h)
            begin
                shift_window({1'b0, tacs_pkg::CLS_OTHER}, -1, -1);
                r    = release_result();
                made = 1'b1;
            end
        end
        else
        begin
            if (in_row >= h)
                restart_frame();
            shift_window({t.is_water, t.tile_class}, t.road_cost, t.zone_road_cost);
            if (in_row > 0)
            begin
                r    = release_result();
                made = 1'b1;
            end
            in_col++;
            if (in_col >= w)
            begin
                in_col = 0;
                in_row++;
            end
        end
        return made;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [tacs_pkg::COST_W-1:0] random_cost();
        case ($urandom_range(0, 9))
            0:       return -1;
            1:       return COST_SAT;
            2:       return $urandom;
            3:       return $urandom_range(2147483000, 2147483647);
            default: return $urandom_range(0, 60);
        endcase
    endfunction

    function automatic tile_t random_tile(input logic kind);
        tile_t t;
        int    r;
        r              = $urandom_range(0, 9);
        t.kind         = kind;
        t.is_water     = ($urandom_range(0, 4) == 0);
        t.tile_class   = (r < 4) ? tacs_pkg::CLS_ROAD : (r < 7) ? tacs_pkg::CLS_ZONE :
                         (r < 9) ? tacs_pkg::CLS_OTHER : CLS_SPARE;
        t.road_cost    = random_cost();
        t.zone_road_cost = random_cost();
        return t;
    endfunction

    function automatic script_row_t cfg_row(input tacs_pkg::reg_idx_t r,
                                            input logic [tacs_pkg::DATA_W-1:0] v);
        script_row_t row;
        row.act   = ACT_WRITE;
        row.idx   = r;
        row.value = v;
        row.item  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    function automatic script_row_t item_row(input logic kind, input logic water,
                                             input logic [1:0] cls, input int rc, input int zc,
                                             input bit typed = 1'b0, input int cost = 0,
                                             input bit last = 1'b0);
        script_row_t row;
        row.act                  = ACT_ITEM;
        row.idx                  = tacs_pkg::REG_GRID_WIDTH;
        row.value                = '0;
        row.item.kind            = kind;
        row.item.is_water        = water;
        row.item.tile_class      = cls;
        row.item.road_cost       = rc;
        row.item.zone_road_cost  = zc;
        row.typed                = typed;
        row.want.access_cost     = cost;
        row.want.last_tile       = last;
        return row;
    endfunction

    task automatic reg_write(input tacs_pkg::reg_idx_t r,
                             input logic [tacs_pkg::DATA_W-1:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        apply_register(r, v);
        @(posedge clk);
    endtask

    // Block idle: every expected cost out and the pipeline empty
    task automatic settle();
        tile_ch.valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic offer(input tile_t t, input bit typed, input tacs_pkg::result_t want);
        int                gap;
        bit                made;
        tacs_pkg::result_t got;
        gap = src_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            tile_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tile_ch.valid          <= 1'b1;
        tile_ch.kind           <= t.kind;
        tile_ch.is_water       <= t.is_water;
        tile_ch.tile_class     <= t.tile_class;
        tile_ch.road_cost      <= t.road_cost;
        tile_ch.zone_road_cost <= t.zone_road_cost;
        @(posedge clk);
        while (!tile_ch.ready)
            @(posedge clk);
        made = stencil_step(t, got);
        if (t.kind == KIND_DRAIN)
            drain_items++;
        else
            tile_items++;
        if (t.kind == KIND_TILE || made)
            counted_items++;
        if (typed)
            pending_costs.push_back(want);
        else if (made)
            pending_costs.push_back(got);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #8_000_000;
        $display("timeout, %0d costs still outstanding", pending_costs.size());
        $display("FAIL tile_access_cost_stencil");
        $finish;
    end

    // Result side: random stalls, steady stretches and a long hold on request
    initial
    begin
        int n;
        cost_ch.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (sink_hold > 0)
            begin
                n             = sink_hold;
                sink_hold     = 0;
                cost_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (sink_steady)
            begin
                cost_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                n = pick_gap();
                if (n > 0)
                begin
                    cost_ch.ready <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                cost_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cost_ch.valid && cost_ch.ready)
        begin
            if (pending_costs.size() == 0)
            begin
                mismatches++;
                $display("%0t: cost %0d last_tile %0b arrived with none expected",
                         $time, cost_ch.access_cost, cost_ch.last_tile);
            end
            else
            begin
                due = pending_costs.pop_front();
                costs_checked++;
                if (cost_ch.access_cost !== due.access_cost)
                begin
                    mismatches++;
                    $display("%0t: access_cost expected %0d got %0d",
                             $time, due.access_cost, cost_ch.access_cost);
                end
                if (cost_ch.last_tile !== due.last_tile)
                begin
                    mismatches++;
                    $display("%0t: last_tile expected %0b got %0b",
                             $time, due.last_tile, cost_ch.last_tile);
                end
            end
        end
    end

    initial
    begin
        int                             phase, w, h, frames, drains, r;
        logic [tacs_pkg::WIDTH_W-1:0]   wv;
        logic [tacs_pkg::HEIGHT_W-1:0]  hv;
        logic [4:0]                     flags;
        logic [tacs_pkg::DATA_W-1:0]    walk_v;

        rst_n                  <= 1'b0;
        psel                   <= 1'b0;
        penable                <= 1'b0;
        pwrite                 <= 1'b0;
        paddr                  <= '0;
        pwdata                 <= '0;
        tile_ch.valid          <= 1'b0;
        tile_ch.kind           <= KIND_TILE;
        tile_ch.is_water       <= 1'b0;
        tile_ch.tile_class     <= tacs_pkg::CLS_OTHER;
        tile_ch.road_cost      <= '0;
        tile_ch.zone_road_cost <= '0;
        mismatches    = 0;
        costs_checked = 0;
        tile_items    = 0;
        drain_items   = 0;
        counted_items = 0;
        settings_used = 0;
        src_steady    = 1'b0;
        sink_steady   = 1'b0;
        sink_hold     = 0;
        predictor_reset();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x2 frame with default flags
        script.push_back(cfg_row(tacs_pkg::REG_GRID_WIDTH, 3));
        script.push_back(cfg_row(tacs_pkg::REG_GRID_HEIGHT, 2));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ROAD, 5, COST_SAT));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ZONE, -1, -1));
        script.push_back(item_row(KIND_TILE, 1, tacs_pkg::CLS_OTHER, -1, -1));
        script.push_back(item_row(KIND_TILE, 0, CLS_SPARE, COST_SAT, COST_SAT, 1, 5, 0));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ROAD, COST_SAT, -1));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ROAD, -1, -1, 1, -1, 0));
        script.push_back(item_row(KIND_DRAIN, 0, tacs_pkg::CLS_OTHER, -1, -1));
        script.push_back(item_row(KIND_DRAIN, 0, tacs_pkg::CLS_OTHER, -1, -1, 1, COST_SAT, 0));
        script.push_back(item_row(KIND_DRAIN, 0, tacs_pkg::CLS_OTHER, -1, -1, 1, -1, 1));
        script.push_back(item_row(KIND_DRAIN, 0, tacs_pkg::CLS_OTHER, -1, -1));
        // water allowed, walk cost at its ceiling: sums saturate
        script.push_back(cfg_row(tacs_pkg::REG_WALK_COST, 32'h7FFF_FFFF));
        script.push_back(cfg_row(tacs_pkg::REG_INCL_WATER, 1));
        script.push_back(item_row(KIND_TILE, 1, tacs_pkg::CLS_OTHER, -1, -1));
        script.push_back(item_row(KIND_DRAIN, 0, tacs_pkg::CLS_OTHER, -1, -1));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ROAD, 10, -1));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ZONE, -1, 7));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ROAD, 0, -1));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ZONE, 0, -1));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_OTHER, -1, -1, 1, COST_SAT, 0));
        // tile past the frame end restarts it, last row never drained
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ROAD, 3, -1));
        script.push_back(cfg_row(tacs_pkg::REG_GRID_WIDTH, 1));
        script.push_back(cfg_row(tacs_pkg::REG_GRID_HEIGHT, 1));
        script.push_back(cfg_row(tacs_pkg::REG_WALK_COST, 0));
        script.push_back(item_row(KIND_TILE, 0, tacs_pkg::CLS_ROAD, 0, -1));
        script.push_back(item_row(KIND_DRAIN, 0, tacs_pkg::CLS_OTHER, -1, -1, 1, 0, 1));

        foreach (script[i])
        begin
            if (script[i].act == ACT_WRITE)
            begin
                settle();
                reg_write(script[i].idx, script[i].value);
            end
            else
            begin
                offer(script[i].item, script[i].typed, script[i].want);
            end
        end
        settings_used = 3;
        counted_items = 0;

        for (phase = 0; counted_items < RANDOM_ITEMS; phase++)
        begin
            case (phase)
                0: begin wv = 7'd8;  hv = 16'd4; end
                1: begin wv = 7'd5;  hv = 16'd3; end
                2: begin wv = 7'($urandom_range(1, 4)); hv = 16'hFFFF; end
                3: begin wv = 7'd64; hv = 16'd2; end
                4: begin wv = 7'd127; hv = 16'd1; end
                5: begin wv = 7'd0;  hv = 16'd0; end
                default:
                begin
                    r  = $urandom_range(0, 9);
                    wv = (r == 0) ? 7'd64 : 7'($urandom_range(1, 6));
                    hv = (r == 0) ? 16'd1 : 16'($urandom_range(1, 5));
                end
            endcase
            flags = 5'($urandom);
            if (phase == 6)
                flags = '0;
            else if (phase == 7)
                flags = '1;
            case ($urandom_range(0, 3))
                0:       walk_v = '0;
                1:       walk_v = 32'h7FFF_FFFF;
                2:       walk_v = $urandom_range(1, 40);
                default: walk_v = $urandom;
            endcase

            settle();
            reg_write(tacs_pkg::REG_GRID_WIDTH, tacs_pkg::DATA_W'(wv));
            reg_write(tacs_pkg::REG_GRID_HEIGHT, tacs_pkg::DATA_W'(hv));
            reg_write(tacs_pkg::REG_INCL_WATER, tacs_pkg::DATA_W'(flags[0]));
            reg_write(tacs_pkg::REG_INCL_ROADS, tacs_pkg::DATA_W'(flags[1]));
            reg_write(tacs_pkg::REG_INCL_ZONES, tacs_pkg::DATA_W'(flags[2]));
            reg_write(tacs_pkg::REG_USE_ZONE_MAP, tacs_pkg::DATA_W'(flags[3]));
            reg_write(tacs_pkg::REG_INCL_ADJ, tacs_pkg::DATA_W'(flags[4]));
            reg_write(tacs_pkg::REG_WALK_COST, walk_v);
            settings_used++;

            src_steady  = ($urandom_range(0, 4) == 0);
            sink_steady = ($urandom_range(0, 4) == 0);
            // long receiver hold while tiles keep coming: block must back up
            if (phase == 0)
            begin
                src_steady  = 1'b1;
                sink_steady = 1'b0;
                sink_hold   = 300;
                // start offering only once the hold is in force
                while (sink_hold != 0)
                    @(posedge clk);
            end
            w = span_w();
            h = span_h();

            if (phase == 2)
            begin
                // frame far too tall to finish; next geometry write drops it
                repeat ($urandom_range(40, 80)) offer(random_tile(KIND_TILE), 1'b0, '0);
            end
            else
            begin
                frames = (w * h > 64) ? 1 : $urandom_range(1, 3);
                repeat (frames)
                begin
                    for (int i = 0; i < w * h; i++)
                    begin
                        if (phase == 1 && i == (w * h) / 2)
                        begin
                            tile_ch.valid <= 1'b0;
                            do
                                @(posedge clk);
                            while (pending_costs.size() != 0);
                        end
                        if (!src_steady && $urandom_range(0, 39) == 0)
                            offer(random_tile(KIND_DRAIN), 1'b0, '0);
                        offer(random_tile(KIND_TILE), 1'b0, '0);
                    end
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        drains = $urandom_range(0, w - 1);
                    else if (r == 1)
                        drains = w + $urandom_range(1, 3);
                    else
                        drains = w;
                    repeat (drains) offer(random_tile(KIND_DRAIN), 1'b0, '0);
                end
            end
        end

        tile_ch.valid <= 1'b0;
        while (pending_costs.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("covered %0d tile items and %0d drain items over %0d register settings",
                 tile_items, drain_items, settings_used);
        $display("%0d costs checked, %0d mismatches", costs_checked, mismatches);
        if (mismatches == 0 && pending_costs.size() == 0)
            $display("PASS tile_access_cost_stencil");
        else
            $display("FAIL tile_access_cost_stencil");
        $finish;
    end

endmodule

/* tile_access_cost_stencil.f */
rtl/tacs_pkg.sv
rtl/tacs_tile_if.sv
rtl/tacs_cost_if.sv
rtl/tacs_cell.sv
rtl/tacs_window.sv
rtl/tacs_eval.sv
rtl/tacs_fifo.sv
rtl/tile_access_cost_stencil.sv
sim/tile_access_cost_stencil_tb.sv
